// ----- sv/bfm_pkg.sv -----
// Shared types and codes for the Brainfuck machine.
`default_nettype none
package bfm_pkg;

    // Instruction codes held in the program store.
    typedef enum logic [2:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } op_t;

    // Result status codes.
    typedef enum logic [3:0] {
        STAT_LOADED    = 4'd0,
        STAT_EXEC      = 4'd1,
        STAT_OUTPUT    = 4'd2,
        STAT_WAIT      = 4'd3,
        STAT_DONE      = 4'd4,
        STAT_RIGHT     = 4'd5,
        STAT_LEFT      = 4'd6,
        STAT_NEG       = 4'd7,
        STAT_UNMATCHED = 4'd8
    } status_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TAPE_CELLS     = 2'd0,
        CFG_ALLOW_NEGATIVE = 2'd1,
        CFG_EOF_KEEPS_CELL = 2'd2,
        CFG_EOF_FILL       = 2'd3
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_SCAN_RD,
        SEQ_SCAN_CHK
    } seq_state_t;

    localparam int CFG_DATA_BITS = 16;
    localparam int TAPE_CELLS_BITS = 9;
    localparam logic [TAPE_CELLS_BITS-1:0] TAPE_CELLS_RESET = 9'd250;

endpackage
`default_nettype wire

// ----- sv/bfm_if.sv -----
// Handshake interfaces for the command and result channels.
`default_nettype none
interface bfm_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [2:0] opcode;
    logic       in_valid;
    logic       in_eof;
    logic [7:0] in_byte;

    modport source (output valid, mode, opcode, in_valid, in_eof, in_byte, input ready);
    modport sink (input valid, mode, opcode, in_valid, in_eof, in_byte, output ready);
endinterface

interface bfm_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  out_byte;
    logic [12:0] prog_counter;
    logic [7:0]  cell_index;

    modport source (output valid, status, out_byte, prog_counter, cell_index, input ready);
    modport sink (input valid, status, out_byte, prog_counter, cell_index, output ready);
endinterface
`default_nettype wire

// ----- sv/bfm_ram.sv -----
// Single-port-write, single-port-read memory with a registered read.
`default_nettype none
module bfm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/brainfuck_machine_step.sv -----
// Top level of the Brainfuck machine: sequencer around program and tape memories.
`default_nettype none
// A load word appends one instruction to the program store when there is
// room; a step word executes one instruction and returns one result word.
// After reset the block first zeroes the tape, one cell a cycle, and accepts
// no word until that pass is over (configuration writes are taken throughout).
// A load or an ordinary step is accepted in SEQ_IDLE, where the program and
// tape memories are read, and finished in SEQ_EXEC, which writes back. The
// result then sits in the output register, and the next word is taken once it
// has left. A bracket that jumps scans the program store through its single
// read port, one instruction per pass through SEQ_SCAN_RD and SEQ_SCAN_CHK.
module brainfuck_machine_step
    import bfm_pkg::*;
#(
    parameter int TAPE_DEPTH = 256,
    parameter int PROG_DEPTH = 4096,
    parameter int CELL_BITS  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    bfm_in_if.sink                        in_ch,
    bfm_out_if.source                     out_ch
);

    localparam int TW = $clog2(TAPE_DEPTH);
    localparam int AW = $clog2(PROG_DEPTH);
    localparam int PW = $clog2(PROG_DEPTH + 1);
    localparam int NW = (TW + 1 > TAPE_CELLS_BITS + 1) ? TW + 1 : TAPE_CELLS_BITS + 1;

    // Configuration registers.
    logic [TAPE_CELLS_BITS-1:0] tape_cells_reg;
    logic                       allow_negative_reg;
    logic                       eof_keeps_cell_reg;
    logic [CFG_DATA_BITS-1:0]   eof_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tape_cells_reg     <= TAPE_CELLS_RESET;
            allow_negative_reg <= 1'b0;
            eof_keeps_cell_reg <= 1'b0;
            eof_fill_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TAPE_CELLS:     tape_cells_reg     <= cfg_data[TAPE_CELLS_BITS-1:0];
                CFG_ALLOW_NEGATIVE: allow_negative_reg <= cfg_data[0];
                CFG_EOF_KEEPS_CELL: eof_keeps_cell_reg <= cfg_data[0];
                CFG_EOF_FILL:       eof_fill_reg       <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Machine state.
    seq_state_t            state_reg, state_next;
    logic [TW-1:0]         clr_reg, clr_next;
    logic [PW-1:0]         len_reg, len_next;
    logic [PW-1:0]         pc_reg, pc_next;
    logic [TW-1:0]         ptr_reg, ptr_next;
    logic                  halted_reg, halted_next;
    status_t               code_reg, code_next;
    logic [PW-1:0]         j_reg, j_next;
    logic [PW-1:0]         depth_reg, depth_next;
    logic                  back_reg, back_next;

    // Latched command word.
    logic                  mode_reg;
    op_t                   opcode_reg;
    logic                  inv_reg;
    logic                  ineof_reg;
    logic [7:0]            inbyte_reg;

    // Result register.
    logic                  ovld_reg, ovld_next;
    status_t               ostat_reg, ostat_next;
    logic [7:0]            obyte_reg, obyte_next;

    // Memory ports.
    logic                  prog_we;
    logic [AW-1:0]         prog_raddr;
    logic [2:0]            prog_rdata;
    logic                  tape_we;
    logic [TW-1:0]         tape_waddr;
    logic [CELL_BITS-1:0]  tape_wdata;
    logic [CELL_BITS-1:0]  tape_rdata;

    logic                  accept;
    logic                  scan_go;
    logic                  scan_fail;
    logic                  scan_found;
    op_t                   op;
    logic [NW-1:0]         cells_ext;
    logic [NW-1:0]         cells_used;
    logic                  right_err;
    logic [63:0]           fill_ext;
    logic [63:0]           byte_ext;
    logic [63:0]           pc_ext;
    logic [63:0]           ptr_ext;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == SEQ_IDLE) && !ovld_reg;
    assign op           = op_t'(prog_rdata);

    bfm_ram #(.DEPTH(PROG_DEPTH), .WIDTH(3)) u_prog (
        .clk   (clk),
        .we    (prog_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (opcode_reg),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    bfm_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(CELL_BITS)) u_tape (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (ptr_reg),
        .rdata (tape_rdata)
    );

    // Effective tape length, clamped to one and to the tape depth.
    always_comb
    begin
        cells_ext = {{(NW - TAPE_CELLS_BITS){1'b0}}, tape_cells_reg};
        if (cells_ext == '0)
        begin
            cells_used = NW'(1);
        end
        else if (cells_ext > NW'(TAPE_DEPTH))
        begin
            cells_used = NW'(TAPE_DEPTH);
        end
        else
        begin
            cells_used = cells_ext;
        end
        right_err = ({{(NW - TW){1'b0}}, ptr_reg} + NW'(1)) >= cells_used;
    end

    assign fill_ext = {{48{eof_fill_reg[15]}}, eof_fill_reg};
    assign byte_ext = {56'd0, inbyte_reg};

    // Bracket scan decisions.
    assign scan_go = (state_reg == SEQ_EXEC) && mode_reg && !halted_reg
                     && (pc_reg < len_reg)
                     && (((op == OP_OPEN) && (tape_rdata == '0))
                         || ((op == OP_CLOSE) && (tape_rdata != '0)));
    assign scan_fail = back_reg ? (j_reg == '0) : (j_reg >= len_reg);
    assign scan_found = (depth_reg == '0)
                        && (back_reg ? (op == OP_OPEN) : (op == OP_CLOSE));

    // Program read address: the current instruction, or the scan position.
    always_comb
    begin
        if (state_reg == SEQ_SCAN_RD)
        begin
            prog_raddr = back_reg ? AW'(j_reg - PW'(1)) : AW'(j_reg);
        end
        else
        begin
            prog_raddr = AW'(pc_reg);
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_CLEAR:
            begin
                if (clr_reg == TW'(TAPE_DEPTH - 1))
                begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC:
            begin
                state_next = scan_go ? SEQ_SCAN_RD : SEQ_IDLE;
            end
            SEQ_SCAN_RD:
            begin
                state_next = scan_fail ? SEQ_IDLE : SEQ_SCAN_CHK;
            end
            SEQ_SCAN_CHK:
            begin
                state_next = scan_found ? SEQ_IDLE : SEQ_SCAN_RD;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        clr_next    = clr_reg;
        len_next    = len_reg;
        pc_next     = pc_reg;
        ptr_next    = ptr_reg;
        halted_next = halted_reg;
        code_next   = code_reg;
        j_next      = j_reg;
        depth_next  = depth_reg;
        back_next   = back_reg;
        ovld_next   = ovld_reg && !out_ch.ready;
        ostat_next  = ostat_reg;
        obyte_next  = obyte_reg;
        prog_we     = 1'b0;
        tape_we     = 1'b0;
        tape_waddr  = ptr_reg;
        tape_wdata  = '0;

        case (state_reg)
            SEQ_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                clr_next   = clr_reg + TW'(1);
            end
            SEQ_EXEC:
            begin
                obyte_next = '0;
                if (!mode_reg)
                begin
                    // Load: append when there is room.
                    if (len_reg < PW'(PROG_DEPTH))
                    begin
                        prog_we  = 1'b1;
                        len_next = len_reg + PW'(1);
                    end
                    ostat_next = STAT_LOADED;
                    ovld_next  = 1'b1;
                end
                else if (halted_reg)
                begin
                    ostat_next = code_reg;
                    ovld_next  = 1'b1;
                end
                else if (pc_reg >= len_reg)
                begin
                    ostat_next = STAT_DONE;
                    ovld_next  = 1'b1;
                end
                else
                begin
                    ostat_next = STAT_EXEC;
                    ovld_next  = !scan_go;
                    pc_next    = pc_reg + PW'(1);
                    case (op)
                        OP_INC:
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_rdata + CELL_BITS'(1);
                        end
                        OP_DEC:
                        begin
                            if (!allow_negative_reg && (tape_rdata == '0))
                            begin
                                ostat_next = STAT_NEG;
                            end
                            else
                            begin
                                tape_we    = 1'b1;
                                tape_wdata = tape_rdata - CELL_BITS'(1);
                            end
                        end
                        OP_RIGHT:
                        begin
                            if (right_err)
                            begin
                                ostat_next = STAT_RIGHT;
                            end
                            else
                            begin
                                ptr_next = ptr_reg + TW'(1);
                            end
                        end
                        OP_LEFT:
                        begin
                            if (ptr_reg == '0)
                            begin
                                ostat_next = STAT_LEFT;
                            end
                            else
                            begin
                                ptr_next = ptr_reg - TW'(1);
                            end
                        end
                        OP_OUT:
                        begin
                            ostat_next = STAT_OUTPUT;
                            obyte_next = tape_rdata[7:0];
                        end
                        OP_IN:
                        begin
                            if (!inv_reg)
                            begin
                                ostat_next = STAT_WAIT;
                                pc_next    = pc_reg;
                            end
                            else if (ineof_reg)
                            begin
                                tape_we    = !eof_keeps_cell_reg;
                                tape_wdata = fill_ext[CELL_BITS-1:0];
                            end
                            else
                            begin
                                tape_we    = 1'b1;
                                tape_wdata = byte_ext[CELL_BITS-1:0];
                            end
                        end
                        OP_OPEN, OP_CLOSE:
                        begin
                            // Start a scan when the bracket jumps; the result then comes at its end.
                            pc_next    = scan_go ? pc_reg : pc_reg + PW'(1);
                            back_next  = (op == OP_CLOSE);
                            j_next     = (op == OP_CLOSE) ? pc_reg : pc_reg + PW'(1);
                            depth_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    // Any error holds pc and halts.
                    if ((ostat_next == STAT_NEG) || (ostat_next == STAT_RIGHT)
                        || (ostat_next == STAT_LEFT))
                    begin
                        pc_next     = pc_reg;
                        halted_next = 1'b1;
                        code_next   = ostat_next;
                    end
                end
            end
            SEQ_SCAN_RD:
            begin
                if (scan_fail)
                begin
                    ostat_next  = STAT_UNMATCHED;
                    ovld_next   = 1'b1;
                    halted_next = 1'b1;
                    code_next   = STAT_UNMATCHED;
                end
                else if (back_reg)
                begin
                    j_next = j_reg - PW'(1);
                end
            end
            SEQ_SCAN_CHK:
            begin
                if (scan_found)
                begin
                    pc_next    = j_reg + PW'(1);
                    ostat_next = STAT_EXEC;
                    ovld_next  = 1'b1;
                end
                else
                begin
                    if (!back_reg)
                    begin
                        j_next = j_reg + PW'(1);
                    end
                    if (op == (back_reg ? OP_CLOSE : OP_OPEN))
                    begin
                        depth_next = depth_reg + PW'(1);
                    end
                    else if (op == (back_reg ? OP_OPEN : OP_CLOSE))
                    begin
                        depth_next = depth_reg - PW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_CLEAR;
            clr_reg    <= '0;
            len_reg    <= '0;
            pc_reg     <= '0;
            ptr_reg    <= '0;
            halted_reg <= 1'b0;
            code_reg   <= STAT_LOADED;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            len_reg    <= len_next;
            pc_reg     <= pc_next;
            ptr_reg    <= ptr_next;
            halted_reg <= halted_next;
            code_reg   <= code_next;
            ovld_reg   <= ovld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        depth_reg <= depth_next;
        back_reg  <= back_next;
        ostat_reg <= ostat_next;
        obyte_reg <= obyte_next;
        if (accept)
        begin
            mode_reg   <= in_ch.mode;
            opcode_reg <= op_t'(in_ch.opcode);
            inv_reg    <= in_ch.in_valid;
            ineof_reg  <= in_ch.in_eof;
            inbyte_reg <= in_ch.in_byte;
        end
    end

    // Result word.
    assign pc_ext              = {{(64 - PW){1'b0}}, pc_reg};
    assign ptr_ext             = {{(64 - TW){1'b0}}, ptr_reg};
    assign out_ch.valid        = ovld_reg;
    assign out_ch.status       = ostat_reg;
    assign out_ch.out_byte     = obyte_reg;
    assign out_ch.prog_counter = pc_ext[12:0];
    assign out_ch.cell_index   = ptr_ext[7:0];

    // The program counter never runs past the loaded program.
    assert property (@(posedge clk) disable iff (!rst_n) pc_reg <= len_reg)
        else $error("pc beyond program length");

    // Once halted, the machine stays halted.
    assert property (@(posedge clk) disable iff (!rst_n) halted_reg |=> halted_reg)
        else $error("halt flag dropped");

    // No word is taken while the tape is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_CLEAR) |-> !in_ch.ready)
        else $error("word accepted during tape clear");

    // A scan that finds its match ends in a result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == SEQ_SCAN_CHK) && scan_found) |=> ovld_reg)
        else $error("scan finished without result");

endmodule
`default_nettype wire
